@@ rtl/core/msws_pkg.sv @@
// Package for the mecanum wheel speed stepper: payload words, register set,
// microcode format and program, and the shared fixed-point saturation helper.
// No dependencies.
package msws_pkg;

  localparam int NumWheels = 4;
  localparam int PcW = 5;
  localparam int ProdW = 35;
  localparam int OpAW = 18;

  localparam logic [15:0] PairSpanRst = 16'd0;
  localparam logic [15:0] InvRadiusRst = 16'd256;
  localparam logic [15:0] CountScaleRst = 16'd93;
  localparam logic [14:0] MinSpeedRst = 15'd366;
  localparam logic [14:0] ErrorBandRst = 15'd102;
  localparam logic [7:0] MinDutyRst = 8'd0;
  localparam logic [7:0] MaxDutyRst = 8'd255;
  localparam logic [7:0] WeightLimitRst = 8'd105;

  typedef struct packed {
    logic               func;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic signed [11:0] delta_front_right;
    logic signed [11:0] delta_front_left;
    logic signed [11:0] delta_back_right;
    logic signed [11:0] delta_back_left;
  } in_t;

  typedef struct packed {
    logic       pin_front_right;
    logic [7:0] pwm_front_right;
    logic       pin_front_left;
    logic [7:0] pwm_front_left;
    logic       pin_back_right;
    logic [7:0] pwm_back_right;
    logic       pin_back_left;
    logic [7:0] pwm_back_left;
    logic       all_settled;
  } out_t;

  typedef enum logic [2:0] {
    REG_PAIR_SPAN    = 3'd0,
    REG_INV_RADIUS   = 3'd1,
    REG_COUNT_SCALE  = 3'd2,
    REG_MIN_SPEED    = 3'd3,
    REG_ERROR_BAND   = 3'd4,
    REG_MIN_DUTY     = 3'd5,
    REG_MAX_DUTY     = 3'd6,
    REG_WEIGHT_LIMIT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] pair_span;
    logic [15:0] inverse_wheel_radius;
    logic [15:0] count_scale;
    logic [14:0] min_speed;
    logic [14:0] error_band;
    logic [7:0]  min_duty;
    logic [7:0]  max_duty;
    logic [7:0]  weight_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] target;
    logic signed [15:0] meas;
    logic [7:0]         weight;
    logic               done;
    logic               left;
    logic               pin;
    logic [7:0]         pwm;
  } step_in_t;

  typedef struct packed {
    logic [7:0] weight;
    logic       done;
    logic       pin;
    logic [7:0] pwm;
  } step_out_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NOP,
    OP_MUL_K,
    OP_LOAD_K,
    OP_MUL_TGT,
    OP_STORE_TGT,
    OP_ZERO_ALL,
    OP_CMD_END,
    OP_OUT,
    OP_MUL_MEAS,
    OP_STEP
  } op_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_TICK,
    C_ZERO,
    C_ALWAYS
  } cond_t;

  typedef struct packed {
    op_t            op;
    cond_t          cond;
    logic [1:0]     wheel;
    logic [PcW-1:0] dest;
  } ucode_t;

  localparam logic [PcW-1:0] PcIdle = 5'd0;
  localparam logic [PcW-1:0] PcZero = 5'd13;
  localparam logic [PcW-1:0] PcCmdEnd = 5'd14;
  localparam logic [PcW-1:0] PcOut = 5'd15;
  localparam logic [PcW-1:0] PcTick = 5'd16;

  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t u;
    u = '{op: OP_IDLE, cond: C_ALWAYS, wheel: 2'd0, dest: PcIdle};
    unique case (pc)
      5'd0:  u = '{op: OP_IDLE,      cond: C_NEXT,   wheel: 2'd0, dest: PcIdle};
      5'd1:  u = '{op: OP_NOP,       cond: C_TICK,   wheel: 2'd0, dest: PcTick};
      5'd2:  u = '{op: OP_NOP,       cond: C_ZERO,   wheel: 2'd0, dest: PcZero};
      5'd3:  u = '{op: OP_MUL_K,     cond: C_NEXT,   wheel: 2'd0, dest: PcIdle};
      5'd4:  u = '{op: OP_LOAD_K,    cond: C_NEXT,   wheel: 2'd0, dest: PcIdle};
      5'd5:  u = '{op: OP_MUL_TGT,   cond: C_NEXT,   wheel: 2'd0, dest: PcIdle};
      5'd6:  u = '{op: OP_STORE_TGT, cond: C_NEXT,   wheel: 2'd0, dest: PcIdle};
      5'd7:  u = '{op: OP_MUL_TGT,   cond: C_NEXT,   wheel: 2'd1, dest: PcIdle};
      5'd8:  u = '{op: OP_STORE_TGT, cond: C_NEXT,   wheel: 2'd1, dest: PcIdle};
      5'd9:  u = '{op: OP_MUL_TGT,   cond: C_NEXT,   wheel: 2'd2, dest: PcIdle};
      5'd10: u = '{op: OP_STORE_TGT, cond: C_NEXT,   wheel: 2'd2, dest: PcIdle};
      5'd11: u = '{op: OP_MUL_TGT,   cond: C_NEXT,   wheel: 2'd3, dest: PcIdle};
      5'd12: u = '{op: OP_STORE_TGT, cond: C_ALWAYS, wheel: 2'd3, dest: PcCmdEnd};
      5'd13: u = '{op: OP_ZERO_ALL,  cond: C_NEXT,   wheel: 2'd0, dest: PcIdle};
      5'd14: u = '{op: OP_CMD_END,   cond: C_NEXT,   wheel: 2'd0, dest: PcIdle};
      5'd15: u = '{op: OP_OUT,       cond: C_ALWAYS, wheel: 2'd0, dest: PcIdle};
      5'd16: u = '{op: OP_MUL_MEAS,  cond: C_NEXT,   wheel: 2'd0, dest: PcIdle};
      5'd17: u = '{op: OP_STEP,      cond: C_NEXT,   wheel: 2'd0, dest: PcIdle};
      5'd18: u = '{op: OP_MUL_MEAS,  cond: C_NEXT,   wheel: 2'd1, dest: PcIdle};
      5'd19: u = '{op: OP_STEP,      cond: C_NEXT,   wheel: 2'd1, dest: PcIdle};
      5'd20: u = '{op: OP_MUL_MEAS,  cond: C_NEXT,   wheel: 2'd2, dest: PcIdle};
      5'd21: u = '{op: OP_STEP,      cond: C_NEXT,   wheel: 2'd2, dest: PcIdle};
      5'd22: u = '{op: OP_MUL_MEAS,  cond: C_NEXT,   wheel: 2'd3, dest: PcIdle};
      5'd23: u = '{op: OP_STEP,      cond: C_ALWAYS, wheel: 2'd3, dest: PcOut};
      default: u = '{op: OP_IDLE,    cond: C_ALWAYS, wheel: 2'd0, dest: PcIdle};
    endcase
    return u;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ProdW-1:0] v);
    logic signed [15:0] r;
    if (v > 35'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -35'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/msws_wheel_step.sv @@
// One step of the bang-bang duty weight controller for a single wheel,
// including the direction pin and PWM drive. Depends on msws_pkg.
module msws_wheel_step (
  input  msws_pkg::cfg_t      cfg,
  input  msws_pkg::step_in_t  step_in,
  output msws_pkg::step_out_t step_out
);

  logic signed [17:0] t18;
  logic signed [17:0] m18;
  logic signed [17:0] ms18;
  logic signed [17:0] eb18;
  logic               neg;
  logic               pos;
  logic               active;
  logic               w_lt;
  logic               w_gt0;
  logic               inc;
  logic               dec;
  logic [7:0]         w_new;
  logic [8:0]         duty9;
  logic [7:0]         duty;
  logic               pin;
  logic [7:0]         pwm;

  always_comb begin
    t18 = {{2{step_in.target[15]}}, step_in.target};
    m18 = {{2{step_in.meas[15]}}, step_in.meas};
    ms18 = {3'b000, cfg.min_speed};
    eb18 = {3'b000, cfg.error_band};
    neg = t18 < -ms18;
    pos = t18 > ms18;
    active = neg | pos;
    w_lt = step_in.weight < cfg.weight_limit;
    w_gt0 = step_in.weight != 8'd0;
    if (neg) begin
      inc = (t18 < m18) && w_lt;
      dec = !inc && ((t18 - eb18) > m18) && w_gt0;
    end else begin
      inc = (t18 > m18) && w_lt;
      dec = !inc && ((t18 + eb18) < m18) && w_gt0;
    end
    if (!active) begin
      w_new = step_in.weight;
    end else if (inc) begin
      w_new = step_in.weight + 8'd1;
    end else if (dec) begin
      w_new = step_in.weight - 8'd1;
    end else begin
      w_new = step_in.weight;
    end
    duty9 = {1'b0, cfg.min_duty} + {1'b0, w_new};
    if (!active) begin
      duty = 8'd0;
    end else if (duty9[8]) begin
      duty = 8'hff;
    end else begin
      duty = duty9[7:0];
    end
    pin = step_in.left ^ pos;
    if (!pin) begin
      pwm = duty;
    end else if (cfg.max_duty >= duty) begin
      pwm = cfg.max_duty - duty;
    end else begin
      pwm = 8'd0;
    end
    if (step_in.done) begin
      step_out.weight = step_in.weight;
      step_out.done = 1'b1;
      step_out.pin = step_in.pin;
      step_out.pwm = step_in.pwm;
    end else begin
      step_out.weight = w_new;
      step_out.done = !active || !(inc || dec);
      step_out.pin = pin;
      step_out.pwm = pwm;
    end
  end

endmodule

@@ rtl/core/mecanum_wheel_speed_stepper_top.sv @@
// Top level of the mecanum wheel speed stepper: microcoded sequencer, shared
// multiplier datapath and wheel state. Depends on msws_pkg and msws_wheel_step.
//
// Usage: every input word is either a velocity command (func 0) or a
// measurement tick (func 1) and yields exactly one result word holding the
// pin and PWM levels of all four wheels and the all-settled flag.
// Input words are taken on in_valid with in_stall low; results leave on
// out_valid with out_stall low. Registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no word is
// in flight, which the block does not enforce. A word is worked through by
// a program in a step table that drives one 18 by 17 bit multiplier,
// registered after each product. The multiplier is used once per wheel and,
// for a command, once more for the yaw term; an all-zero command skips it.
// The next word can be taken in the cycle after the result is loaded into
// the output register, even while that result still waits for the receiver.
// If the receiver stalls, the result holds and the program waits at its
// output step until the output register is free.
// Reset clears the program counter, the output valid and the wheel targets,
// weights, pins and PWM levels, sets all done flags and loads register defaults.
module mecanum_wheel_speed_stepper_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  msws_pkg::in_t   in_word,
  output logic            out_valid,
  input  logic            out_stall,
  output msws_pkg::out_t  out_word,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  localparam int NW = msws_pkg::NumWheels;
  localparam int PW = msws_pkg::ProdW;
  localparam int AW = msws_pkg::OpAW;

  msws_pkg::cfg_t cfg_r;
  msws_pkg::in_t in_r;
  msws_pkg::out_t out_r;
  logic out_valid_r;
  logic [msws_pkg::PcW-1:0] pc_r;
  logic [msws_pkg::PcW-1:0] pc_nxt;
  logic signed [16:0] k_r;
  logic signed [PW-1:0] prod_r;
  logic signed [15:0] tgt_r [NW];
  logic [7:0] wgt_r [NW];
  logic [NW-1:0] done_r;
  logic [NW-1:0] pin_r;
  logic [7:0] pwm_r [NW];

  msws_pkg::ucode_t uc;
  logic in_acc;
  logic out_free;
  logic is_zero;
  logic jump;
  logic hold;
  logic signed [AW-1:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] vx18;
  logic signed [AW-1:0] vy18;
  logic signed [AW-1:0] k18;
  logic signed [AW-1:0] sum_w;
  logic signed [11:0] delta_sel;
  msws_pkg::step_in_t step_in;
  msws_pkg::step_out_t step_out;

  assign uc = msws_pkg::ucode_rom(pc_r);
  assign in_stall = uc.op != msws_pkg::OP_IDLE;
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word = out_r;
  assign is_zero = (in_r.vel_x == 16'sd0) && (in_r.vel_y == 16'sd0) &&
                   (in_r.yaw_rate == 16'sd0);

  always_comb begin
    unique case (uc.cond)
      msws_pkg::C_NEXT:   jump = 1'b0;
      msws_pkg::C_TICK:   jump = in_r.func;
      msws_pkg::C_ZERO:   jump = is_zero;
      msws_pkg::C_ALWAYS: jump = 1'b1;
      default:            jump = 1'b0;
    endcase
    hold = ((uc.op == msws_pkg::OP_IDLE) && !in_valid) ||
           ((uc.op == msws_pkg::OP_OUT) && !out_free);
    if (hold) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = uc.dest;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_comb begin
    vx18 = {{2{in_r.vel_x[15]}}, in_r.vel_x};
    vy18 = {{2{in_r.vel_y[15]}}, in_r.vel_y};
    k18 = {k_r[16], k_r};
    sum_w = vx18 + (((uc.wheel == 2'd0) || (uc.wheel == 2'd3)) ? vy18 : -vy18) +
            (((uc.wheel == 2'd1) || (uc.wheel == 2'd3)) ? k18 : -k18);
    unique case (uc.wheel)
      2'd0:    delta_sel = in_r.delta_front_right;
      2'd1:    delta_sel = in_r.delta_front_left;
      2'd2:    delta_sel = in_r.delta_back_right;
      2'd3:    delta_sel = in_r.delta_back_left;
      default: delta_sel = in_r.delta_front_right;
    endcase
    unique case (uc.op)
      msws_pkg::OP_MUL_K: begin
        mul_a = {{2{in_r.yaw_rate[15]}}, in_r.yaw_rate};
        mul_b = {1'b0, cfg_r.pair_span};
      end
      msws_pkg::OP_MUL_TGT: begin
        mul_a = sum_w;
        mul_b = {1'b0, cfg_r.inverse_wheel_radius};
      end
      default: begin
        mul_a = {{6{delta_sel[11]}}, delta_sel};
        mul_b = {1'b0, cfg_r.count_scale};
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    step_in.target = tgt_r[uc.wheel];
    step_in.meas = msws_pkg::sat16(prod_r);
    step_in.weight = wgt_r[uc.wheel];
    step_in.done = done_r[uc.wheel];
    step_in.left = uc.wheel[0];
    step_in.pin = pin_r[uc.wheel];
    step_in.pwm = pwm_r[uc.wheel];
  end

  msws_wheel_step u_step (
    .cfg      (cfg_r),
    .step_in  (step_in),
    .step_out (step_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pair_span <= msws_pkg::PairSpanRst;
      cfg_r.inverse_wheel_radius <= msws_pkg::InvRadiusRst;
      cfg_r.count_scale <= msws_pkg::CountScaleRst;
      cfg_r.min_speed <= msws_pkg::MinSpeedRst;
      cfg_r.error_band <= msws_pkg::ErrorBandRst;
      cfg_r.min_duty <= msws_pkg::MinDutyRst;
      cfg_r.max_duty <= msws_pkg::MaxDutyRst;
      cfg_r.weight_limit <= msws_pkg::WeightLimitRst;
    end else if (cfg_we) begin
      unique case (msws_pkg::reg_idx_t'(cfg_index))
        msws_pkg::REG_PAIR_SPAN:    cfg_r.pair_span <= cfg_data;
        msws_pkg::REG_INV_RADIUS:   cfg_r.inverse_wheel_radius <= cfg_data;
        msws_pkg::REG_COUNT_SCALE:  cfg_r.count_scale <= cfg_data;
        msws_pkg::REG_MIN_SPEED:    cfg_r.min_speed <= cfg_data[14:0];
        msws_pkg::REG_ERROR_BAND:   cfg_r.error_band <= cfg_data[14:0];
        msws_pkg::REG_MIN_DUTY:     cfg_r.min_duty <= cfg_data[7:0];
        msws_pkg::REG_MAX_DUTY:     cfg_r.max_duty <= cfg_data[7:0];
        msws_pkg::REG_WEIGHT_LIMIT: cfg_r.weight_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= msws_pkg::PcIdle;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if ((uc.op == msws_pkg::OP_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_word;
    end
    if ((uc.op == msws_pkg::OP_MUL_K) || (uc.op == msws_pkg::OP_MUL_TGT) ||
        (uc.op == msws_pkg::OP_MUL_MEAS)) begin
      prod_r <= prod;
    end
    if (uc.op == msws_pkg::OP_LOAD_K) begin
      k_r <= prod_r[32:16];
    end
    if ((uc.op == msws_pkg::OP_OUT) && out_free) begin
      out_r.pin_front_right <= pin_r[0];
      out_r.pwm_front_right <= pwm_r[0];
      out_r.pin_front_left <= pin_r[1];
      out_r.pwm_front_left <= pwm_r[1];
      out_r.pin_back_right <= pin_r[2];
      out_r.pwm_back_right <= pwm_r[2];
      out_r.pin_back_left <= pin_r[3];
      out_r.pwm_back_left <= pwm_r[3];
      out_r.all_settled <= &done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NW; i++) begin
        tgt_r[i] <= 16'sd0;
        wgt_r[i] <= 8'd0;
        pwm_r[i] <= 8'd0;
      end
      done_r <= '1;
      pin_r <= '0;
    end else begin
      unique case (uc.op)
        msws_pkg::OP_STORE_TGT: begin
          tgt_r[uc.wheel] <= msws_pkg::sat16(prod_r >>> 12);
        end
        msws_pkg::OP_ZERO_ALL: begin
          for (int i = 0; i < NW; i++) begin
            tgt_r[i] <= 16'sd0;
            wgt_r[i] <= 8'd0;
            pwm_r[i] <= 8'd0;
          end
          pin_r <= '0;
        end
        msws_pkg::OP_CMD_END: begin
          done_r <= '0;
        end
        msws_pkg::OP_STEP: begin
          wgt_r[uc.wheel] <= step_out.weight;
          done_r[uc.wheel] <= step_out.done;
          pin_r[uc.wheel] <= step_out.pin;
          pwm_r[uc.wheel] <= step_out.pwm;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/msws_checker.sv @@
// Port-level checker for the mecanum wheel speed stepper, bound to the top
// level. Depends on msws_pkg and mecanum_wheel_speed_stepper_top.
module msws_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input msws_pkg::out_t out_word
);

  logic [1:0] outst_r;
  logic [1:0] outst_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    outst_nxt = outst_r + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= 2'd0;
    end else begin
      outst_r <= outst_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result word valid right after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("Stalled result word changed or dropped.");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outst_r != 2'd0)
    else $error("Result word offered with no input word outstanding.");

  a_bounded_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    outst_r != 2'd3)
    else $error("More than two words in flight.");

endmodule

bind mecanum_wheel_speed_stepper_top msws_checker u_msws_checker (.*);
